[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL in this folder.
// Each use sits on a line of its own and names clk_i and rst_ni of the module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[rtl/core/psmc_pkg.sv]
`timescale 1ns / 1ps

package psmc_pkg;

  // Event opcodes
  localparam logic [3:0] OpReset       = 4'd0;
  localparam logic [3:0] OpInitDone    = 4'd1;
  localparam logic [3:0] OpSetDuration = 4'd2;
  localparam logic [3:0] OpSeek        = 4'd3;
  localparam logic [3:0] OpSetRate     = 4'd4;
  localparam logic [3:0] OpPlay        = 4'd5;
  localparam logic [3:0] OpPause       = 4'd6;
  localparam logic [3:0] OpStall       = 4'd7;
  localparam logic [3:0] OpCanPlay     = 4'd8;
  localparam logic [3:0] OpEnded       = 4'd9;
  localparam logic [3:0] OpError       = 4'd10;

  // Playback state codes
  localparam logic [2:0] StInit      = 3'd0;
  localparam logic [2:0] StPaused    = 3'd1;
  localparam logic [2:0] StBuffering = 3'd2;
  localparam logic [2:0] StPlaying   = 3'd3;
  localparam logic [2:0] StSeeking   = 3'd4;
  localparam logic [2:0] StWaitKey   = 3'd5;
  localparam logic [2:0] StEnded     = 3'd6;
  localparam logic [2:0] StErrored   = 3'd7;

  // Rate in signed Q8.16
  localparam int unsigned RateW = 25;
  localparam logic signed [RateW-1:0] RateOne = 25'sh0010000;
  localparam logic signed [RateW-1:0] RateMax = 25'sh0FFFFFF;
  localparam logic signed [RateW-1:0] RateMin = 25'sh1000000;

  // Stream word layout
  localparam int unsigned OpW       = 4;
  localparam int unsigned OperandW  = 41;
  localparam int unsigned InDataW   = 112;
  localparam int unsigned InUserW   = 5;
  localparam int unsigned OutTimeW  = 40;
  localparam int unsigned OutDataW  = 48;

endpackage

[rtl/core/playback_state_media_clock.sv]
`timescale 1ns / 1ps
// The result word of an accepted event is registered and offered in the next cycle.
// Throughput: one event per cycle unless the master side stalls. The elapsed-time
// multiply, clamp and state update all settle in one pass ahead of the result register.
// Reset: rst_ni clears the state to init, rate one, zero anchor, unknown duration,
// and empties the result register.
module playback_state_media_clock #(
  parameter int unsigned TIME_BITS = 40
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [63:0] wall_ms, [104:64] operand, [111:105] zero
  input  logic [psmc_pkg::InDataW-1:0]   s_axis_tdata,
  // [3:0] opcode, [4] operand_known
  input  logic [psmc_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] play_state, [3] state_changed, [4] seek_fired, [44:5] media_time, [47:45] zero
  output logic [psmc_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam logic [63:0] TimeMax = (64'd1 << TIME_BITS) - 64'd1;

  // Player state
  logic [2:0]                         status_q, status_d;
  logic                               will_play_q, will_play_d;
  logic [TIME_BITS-1:0]               anchor_media_q, anchor_media_d;
  logic [63:0]                        anchor_wall_q, anchor_wall_d;
  logic signed [psmc_pkg::RateW-1:0]  rate_q, rate_d;
  logic [TIME_BITS-1:0]               duration_q, duration_d;
  logic                               dur_known_q, dur_known_d;

  // Result register
  logic                               out_valid_q;
  logic [psmc_pkg::OutDataW-1:0]      out_data_q, out_data_d;

  // Event fields
  logic [psmc_pkg::OpW-1:0]           opcode;
  logic [63:0]                        wall_ms;
  logic signed [psmc_pkg::OperandW-1:0] operand;
  logic                               operand_known;
  logic                               in_accept;

  // Clock arithmetic
  logic [63:0]                        elapsed;
  logic [psmc_pkg::RateW-1:0]         rate_mag;
  logic [56:0]                        prod_lo, prod_hi;
  logic [63:0]                        delta;
  logic [63:0]                        anchor_ext;
  logic [63:0]                        raw_ext;
  logic [TIME_BITS-1:0]               raw_time;
  logic [TIME_BITS-1:0]               time_now;
  logic [TIME_BITS-1:0]               op_time;
  logic signed [psmc_pkg::RateW-1:0]  rate_sat;
  logic [2:0]                         seek_status;
  logic                               seek_will;
  logic                               reanchor;
  logic                               seek_fired;
  logic [TIME_BITS-1:0]               time_base;
  logic [TIME_BITS-1:0]               time_out;
  logic [63:0]                        time_out_ext;

  // Result side checks
  logic                               out_stall;
  logic                               out_seek_ok;

  assign opcode        = s_axis_tuser[psmc_pkg::OpW-1:0];
  assign operand_known = s_axis_tuser[4];
  assign wall_ms       = s_axis_tdata[63:0];
  assign operand       = s_axis_tdata[104:64];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Scale the elapsed wall time by the rate magnitude in two 32-bit halves
  assign elapsed  = wall_ms - anchor_wall_q;
  assign rate_mag = rate_q[psmc_pkg::RateW-1] ? psmc_pkg::RateW'(-rate_q)
                                               : psmc_pkg::RateW'(rate_q);
  assign prod_lo  = 57'(elapsed[31:0]) * 57'(rate_mag);
  assign prod_hi  = 57'(elapsed[63:32]) * 57'(rate_mag);
  assign delta    = (|prod_hi[56:47]) ? '1
                  : (64'({prod_hi[46:0], 16'd0}) + 64'(prod_lo[56:16]));

  // Advance the anchor, saturating at both ends of the time range
  assign anchor_ext = 64'(anchor_media_q);
  always_comb begin
    if (!rate_q[psmc_pkg::RateW-1]) begin
      raw_ext = (delta > (TimeMax - anchor_ext)) ? TimeMax : (anchor_ext + delta);
    end else begin
      raw_ext = (delta >= anchor_ext) ? 64'd0 : (anchor_ext - delta);
    end
  end
  assign raw_time = TIME_BITS'(raw_ext);

  // Media time at this wall time, before the event acts
  always_comb begin
    if (status_q != psmc_pkg::StPlaying) begin
      time_now = anchor_media_q;
    end else if (dur_known_q && (raw_time > duration_q)) begin
      time_now = duration_q;
    end else begin
      time_now = raw_time;
    end
  end

  // Clamp a time operand into the time range
  always_comb begin
    if (operand[psmc_pkg::OperandW-1]) begin
      op_time = '0;
    end else if (64'(operand[psmc_pkg::OperandW-2:0]) > TimeMax) begin
      op_time = TIME_BITS'(TimeMax);
    end else begin
      op_time = TIME_BITS'(64'(operand[psmc_pkg::OperandW-2:0]));
    end
  end

  // Saturate a rate operand into Q8.16
  always_comb begin
    if ((&operand[40:24]) || !(|operand[40:24])) begin
      rate_sat = operand[24:0];
    end else if (operand[psmc_pkg::OperandW-1]) begin
      rate_sat = psmc_pkg::RateMin;
    end else begin
      rate_sat = psmc_pkg::RateMax;
    end
  end

  // State entered when a seek starts
  always_comb begin
    seek_status = status_q;
    seek_will   = will_play_q;
    unique case (status_q) inside
      psmc_pkg::StPlaying, psmc_pkg::StBuffering, psmc_pkg::StWaitKey: begin
        seek_status = psmc_pkg::StSeeking;
        seek_will   = 1'b1;
      end
      psmc_pkg::StPaused, psmc_pkg::StEnded: begin
        seek_status = psmc_pkg::StSeeking;
        seek_will   = 1'b0;
      end
      default: ;
    endcase
  end

  // Decode the event and form the next state
  always_comb begin
    status_d       = status_q;
    will_play_d    = will_play_q;
    anchor_media_d = anchor_media_q;
    anchor_wall_d  = anchor_wall_q;
    rate_d         = rate_q;
    duration_d     = duration_q;
    dur_known_d    = dur_known_q;
    reanchor       = 1'b0;
    seek_fired     = 1'b0;
    unique case (opcode)
      psmc_pkg::OpReset: begin
        status_d       = psmc_pkg::StInit;
        will_play_d    = 1'b0;
        anchor_media_d = '0;
        anchor_wall_d  = wall_ms;
        rate_d         = psmc_pkg::RateOne;
        duration_d     = '0;
        dur_known_d    = 1'b0;
        reanchor       = 1'b1;
      end
      psmc_pkg::OpInitDone: begin
        if (status_q == psmc_pkg::StInit) begin
          status_d = will_play_q ? psmc_pkg::StBuffering : psmc_pkg::StPaused;
        end
      end
      psmc_pkg::OpSetDuration: begin
        dur_known_d = operand_known;
        duration_d  = operand_known ? op_time : '0;
        // only a held clock can lie past a new duration
        if (operand_known && (status_q != psmc_pkg::StPlaying) &&
            (anchor_media_q > op_time)) begin
          seek_fired     = 1'b1;
          anchor_media_d = op_time;
          anchor_wall_d  = wall_ms;
          reanchor       = 1'b1;
          status_d       = seek_status;
          will_play_d    = seek_will;
        end
      end
      psmc_pkg::OpSeek: begin
        if (status_q != psmc_pkg::StInit) begin
          seek_fired     = 1'b1;
          anchor_media_d = (dur_known_q && (op_time > duration_q)) ? duration_q : op_time;
          anchor_wall_d  = wall_ms;
          reanchor       = 1'b1;
          status_d       = seek_status;
          will_play_d    = seek_will;
        end
      end
      psmc_pkg::OpSetRate: begin
        anchor_media_d = time_now;
        anchor_wall_d  = wall_ms;
        reanchor       = 1'b1;
        rate_d         = rate_sat;
      end
      psmc_pkg::OpPlay: begin
        anchor_media_d = time_now;
        anchor_wall_d  = wall_ms;
        reanchor       = 1'b1;
        will_play_d    = 1'b1;
        if (status_q == psmc_pkg::StPaused) begin
          status_d = psmc_pkg::StBuffering;
        end else if (status_q == psmc_pkg::StEnded) begin
          seek_fired     = 1'b1;
          anchor_media_d = '0;
          status_d       = psmc_pkg::StSeeking;
        end
      end
      psmc_pkg::OpPause: begin
        anchor_media_d = time_now;
        anchor_wall_d  = wall_ms;
        reanchor       = 1'b1;
        will_play_d    = 1'b0;
        if ((status_q == psmc_pkg::StPlaying) || (status_q == psmc_pkg::StBuffering) ||
            (status_q == psmc_pkg::StWaitKey)) begin
          status_d = psmc_pkg::StPaused;
        end
      end
      psmc_pkg::OpStall: begin
        if (status_q == psmc_pkg::StPlaying) begin
          anchor_media_d = time_now;
          anchor_wall_d  = wall_ms;
          reanchor       = 1'b1;
          status_d       = psmc_pkg::StBuffering;
        end
      end
      psmc_pkg::OpCanPlay: begin
        anchor_media_d = time_now;
        anchor_wall_d  = wall_ms;
        reanchor       = 1'b1;
        if ((status_q == psmc_pkg::StBuffering) || (status_q == psmc_pkg::StWaitKey) ||
            (status_q == psmc_pkg::StSeeking)) begin
          status_d = will_play_q ? psmc_pkg::StPlaying : psmc_pkg::StPaused;
        end
      end
      psmc_pkg::OpEnded: begin
        if ((status_q != psmc_pkg::StEnded) && (status_q != psmc_pkg::StErrored)) begin
          anchor_media_d = dur_known_q ? duration_q : time_now;
          anchor_wall_d  = wall_ms;
          reanchor       = 1'b1;
          status_d       = psmc_pkg::StEnded;
        end
      end
      psmc_pkg::OpError: begin
        if (status_q != psmc_pkg::StErrored) begin
          anchor_media_d = time_now;
          anchor_wall_d  = wall_ms;
          reanchor       = 1'b1;
          status_d       = psmc_pkg::StErrored;
        end
      end
      default: ;
    endcase
  end

  // Media time after the event: a fresh anchor has no elapsed time to add
  always_comb begin
    time_base = reanchor ? anchor_media_d : raw_time;
    if (status_d != psmc_pkg::StPlaying) begin
      time_out = anchor_media_d;
    end else if (dur_known_d && (time_base > duration_d)) begin
      time_out = duration_d;
    end else begin
      time_out = time_base;
    end
  end
  assign time_out_ext = 64'(time_out);

  assign out_data_d = {3'd0, time_out_ext[psmc_pkg::OutTimeW-1:0], seek_fired,
                       (status_d != status_q), status_d};

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q       <= psmc_pkg::StInit;
      will_play_q    <= 1'b0;
      anchor_media_q <= '0;
      anchor_wall_q  <= '0;
      rate_q         <= psmc_pkg::RateOne;
      duration_q     <= '0;
      dur_known_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (in_accept) begin
        status_q       <= status_d;
        will_play_q    <= will_play_d;
        anchor_media_q <= anchor_media_d;
        anchor_wall_q  <= anchor_wall_d;
        rate_q         <= rate_d;
        duration_q     <= duration_d;
        dur_known_q    <= dur_known_d;
        out_valid_q    <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q    <= 1'b0;
      end
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
    end
  end

  // Hold conditions on the result side
  assign out_stall   = m_axis_tvalid && !m_axis_tready;
  assign out_seek_ok = (out_data_q[2:0] == psmc_pkg::StSeeking) ||
                       (out_data_q[2:0] == psmc_pkg::StErrored);

`include "assert_macros.svh"

  `ASSERT_PROP(a_event_gives_word, (in_accept |=> m_axis_tvalid), "accepted event lost its result")
  `ASSERT_PROP(a_word_held, (out_stall |=> (m_axis_tvalid && $stable(m_axis_tdata))), "word dropped")
  `ASSERT_NEVER(a_seek_state, (out_valid_q && out_data_q[4] && !out_seek_ok), "seek outside seeking")

endmodule
